FILE: rtl/delta_r_nearest_match_macros.svh
// Assertion helpers shared by the block's checking code.
`ifndef DELTA_R_NEAREST_MATCH_MACROS_SVH
`define DELTA_R_NEAREST_MATCH_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DRNM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("delta_r_nearest_match: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define DRNM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("delta_r_nearest_match: next-cycle check failed");

`endif

FILE: rtl/drnm_pkg.sv
package drnm_pkg;

  // Field widths
  localparam int ETA_W  = 13;
  localparam int PHI_W  = 12;
  localparam int KIND_W = 2;
  localparam int IDX_W  = 7;
  localparam int DIST_W = 26;
  localparam int REF_W  = ETA_W + PHI_W;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_START = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

  // Register word index (paddr bit 2 selects the word)
  localparam logic REG_LIMIT = 1'b0;

  // Arithmetic constants, LSB pi/2048
  localparam logic [PHI_W-1:0]  PHI_PI      = 12'd2048;
  localparam logic [PHI_W:0]    PHI_TWO_PI  = 13'd4096;
  localparam logic [DIST_W-1:0] DIST_MAX    = 26'h3FF_FFFF;
  localparam logic [DIST_W-1:0] LIMIT_RESET = 26'd17005;
  localparam logic [IDX_W-1:0]  NO_MATCH    = 7'h7F;

  // Read request tag that travels with the stored entry
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
  } ref_tag_t;

  // Distance result and pipeline status
  typedef struct packed {
    logic              busy;
    logic              valid;
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] dist_sq;
  } dist_res_t;

endpackage

FILE: rtl/drnm_ref_mem.sv
module drnm_ref_mem #(
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [drnm_pkg::REF_W-1:0] wr_data,
  input  drnm_pkg::ref_tag_t         rd_tag,
  input  logic [AW-1:0]              rd_addr,
  output logic [drnm_pkg::REF_W-1:0] rd_data,
  output drnm_pkg::ref_tag_t         rd_tag_q
);

  logic [drnm_pkg::REF_W-1:0] mem [DEPTH];
  logic [drnm_pkg::REF_W-1:0] rd_data_r;
  drnm_pkg::ref_tag_t         rd_tag_r;

  // Write one entry per load
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, tag follows the data
  always_ff @(posedge clk) begin
    if (rd_tag.valid) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_tag_r <= '0;
    end else begin
      rd_tag_r <= rd_tag;
    end
  end

  assign rd_data  = rd_data_r;
  assign rd_tag_q = rd_tag_r;

endmodule

FILE: rtl/drnm_dist.sv
module drnm_dist (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic signed [drnm_pkg::ETA_W-1:0] q_eta,
  input  logic signed [drnm_pkg::PHI_W-1:0] q_phi,
  input  logic [drnm_pkg::REF_W-1:0]        ref_data,
  input  drnm_pkg::ref_tag_t                tag_in,
  output drnm_pkg::dist_res_t               res
);

  localparam int EW = drnm_pkg::ETA_W;
  localparam int PW = drnm_pkg::PHI_W;
  localparam int DW = drnm_pkg::DIST_W;

  logic [EW-1:0] r_eta;
  logic [PW-1:0] r_phi;
  logic [EW:0]   de;
  logic [EW:0]   de_neg;
  logic [EW-1:0] ae;
  logic [PW:0]   dp;
  logic [PW:0]   dp_neg;
  logic [PW-1:0] ap_raw;
  logic [PW:0]   ap_wrap;
  logic [PW-1:0] ap;
  logic [DW:0]   sum;

  logic [EW-1:0]           ae_r;
  logic [PW-1:0]           ap_r;
  logic [2*EW-1:0]         ae2_r;
  logic [2*PW-1:0]         ap2_r;
  logic [DW-1:0]           dist_r;
  logic [drnm_pkg::IDX_W-1:0] idx1_r, idx2_r, idx3_r;
  logic                    v1_r, v2_r, v3_r;

  assign r_eta = ref_data[drnm_pkg::REF_W-1:PW];
  assign r_phi = ref_data[PW-1:0];

  // Absolute eta difference
  assign de     = {q_eta[EW-1], q_eta} - {r_eta[EW-1], r_eta};
  assign de_neg = -de;
  assign ae     = de[EW] ? de_neg[EW-1:0] : de[EW-1:0];

  // Absolute phi difference, folded about pi
  assign dp      = {q_phi[PW-1], q_phi} - {r_phi[PW-1], r_phi};
  assign dp_neg  = -dp;
  assign ap_raw  = dp[PW] ? dp_neg[PW-1:0] : dp[PW-1:0];
  assign ap_wrap = drnm_pkg::PHI_TWO_PI - {1'b0, ap_raw};
  assign ap      = (ap_raw > drnm_pkg::PHI_PI) ? ap_wrap[PW-1:0] : ap_raw;

  // Sum of squares, saturated
  assign sum = {1'b0, ae2_r} + {{(DW + 1 - 2*PW){1'b0}}, ap2_r};

  // Stage data: differences, squares, saturated sum
  always_ff @(posedge clk) begin
    ae_r   <= ae;
    ap_r   <= ap;
    idx1_r <= tag_in.idx;
    ae2_r  <= ae_r * ae_r;
    ap2_r  <= ap_r * ap_r;
    idx2_r <= idx1_r;
    dist_r <= sum[DW] ? drnm_pkg::DIST_MAX : sum[DW-1:0];
    idx3_r <= idx2_r;
  end

  // Advance stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= tag_in.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign res.busy    = tag_in.valid | v1_r | v2_r | v3_r;
  assign res.valid   = v3_r;
  assign res.idx     = idx3_r;
  assign res.dist_sq = dist_r;

endmodule

FILE: rtl/delta_r_nearest_match.sv
// Nearest reference object by squared angular distance. Start items clear the
// reference list, load items append (eta, phi) at the next free entry of a
// MAX_REFS-deep memory and are dropped once it is full, query items return the
// lowest index of minimum deta^2 + dphi^2 (dphi folded about pi, angles in
// units of pi/2048) and report a match only when that minimum is strictly below
// the limit register at byte address 0. During a query the memory read port
// delivers one stored object per cycle into the distance pipeline, which then
// drains before the result is registered; an empty list skips the scan.
// A finished result waits in the output register while the next item is
// taken; a query that finishes while that register is still full holds
// until it is taken.
`include "delta_r_nearest_match_macros.svh"

module delta_r_nearest_match #(
  parameter int MAX_REFS = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input items
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [drnm_pkg::KIND_W-1:0]         in_kind,
  input  logic signed [drnm_pkg::ETA_W-1:0]   in_eta,
  input  logic signed [drnm_pkg::PHI_W-1:0]   in_phi,
  // Result items
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [drnm_pkg::IDX_W-1:0]   out_match_index,
  output logic                                out_found,
  output logic [drnm_pkg::DIST_W-1:0]         out_best_dist_sq,
  // Configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [drnm_pkg::CFG_AW-1:0]         paddr,
  input  logic [drnm_pkg::CFG_DW-1:0]         pwdata,
  output logic [drnm_pkg::CFG_DW-1:0]         prdata,
  output logic                                pready
);

  localparam int AW = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
  localparam int CW = $clog2(MAX_REFS + 1);
  localparam int DW = drnm_pkg::DIST_W;
  localparam int IW = drnm_pkg::IDX_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN
  } state_t;

  state_t state_r;

  logic [CW-1:0] ref_count_r;
  logic [CW-1:0] scan_k_r;
  logic [DW-1:0] limit_r;
  logic [DW-1:0] best_r;
  logic [IW-1:0] best_idx_r;
  logic signed [drnm_pkg::ETA_W-1:0] q_eta_r;
  logic signed [drnm_pkg::PHI_W-1:0] q_phi_r;

  logic                 out_valid_r;
  logic [IW-1:0]        out_match_index_r;
  logic                 out_found_r;
  logic [DW-1:0]        out_best_dist_sq_r;

  logic                 in_take;
  logic                 is_load;
  logic                 is_query;
  logic                 wr_en;
  logic                 out_take;
  logic                 out_free;
  logic                 finish;
  logic                 last_read;
  logic                 best_found;
  logic [CW-1:0]        scan_k_inc;

  drnm_pkg::ref_tag_t         rd_tag;
  drnm_pkg::ref_tag_t         rd_tag_q;
  logic [drnm_pkg::REF_W-1:0] rd_data;
  drnm_pkg::dist_res_t        res;

  // Handshake decode
  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign is_load   = in_take && (in_kind == drnm_pkg::KIND_LOAD);
  assign is_query  = in_take && (in_kind == drnm_pkg::KIND_QUERY);
  assign wr_en     = is_load && (ref_count_r < CW'(MAX_REFS));
  assign out_take  = out_valid_r && !out_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // Scan control
  assign scan_k_inc = CW'(scan_k_r + 1'b1);
  assign last_read  = (scan_k_inc == ref_count_r);
  assign finish     = (state_r == S_DRAIN) && !rd_tag_q.valid && !res.busy && out_free;
  assign best_found = (best_r < limit_r);

  assign rd_tag.valid = (state_r == S_SCAN);
  assign rd_tag.idx   = IW'(scan_k_r);

  drnm_ref_mem #(
    .DEPTH(MAX_REFS)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_addr  (ref_count_r[AW-1:0]),
    .wr_data  ({in_eta, in_phi}),
    .rd_tag   (rd_tag),
    .rd_addr  (scan_k_r[AW-1:0]),
    .rd_data  (rd_data),
    .rd_tag_q (rd_tag_q)
  );

  drnm_dist u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_eta    (q_eta_r),
    .q_phi    (q_phi_r),
    .ref_data (rd_data),
    .tag_in   (rd_tag_q),
    .res      (res)
  );

  // Sequencer, list count and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ref_count_r <= '0;
      scan_k_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_take && !finish) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_take && (in_kind == drnm_pkg::KIND_START)) begin
            ref_count_r <= '0;
          end
          if (wr_en) begin
            ref_count_r <= CW'(ref_count_r + 1'b1);
          end
          if (is_query) begin
            scan_k_r <= '0;
            state_r  <= (ref_count_r == '0) ? S_DRAIN : S_SCAN;
          end
        end
        S_SCAN: begin
          scan_k_r <= scan_k_inc;
          if (last_read) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (finish) begin
            out_valid_r        <= 1'b1;
            out_found_r        <= best_found;
            out_match_index_r  <= best_found ? best_idx_r : drnm_pkg::NO_MATCH;
            out_best_dist_sq_r <= best_r;
            state_r            <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Hold the query and track the running minimum; ties keep the lower index
  always_ff @(posedge clk) begin
    if (is_query) begin
      q_eta_r    <= in_eta;
      q_phi_r    <= in_phi;
      best_r     <= drnm_pkg::DIST_MAX;
      best_idx_r <= '0;
    end else if (res.valid && (res.dist_sq < best_r)) begin
      best_r     <= res.dist_sq;
      best_idx_r <= res.idx;
    end
  end

  // Limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= drnm_pkg::LIMIT_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == drnm_pkg::REG_LIMIT)) begin
      limit_r <= pwdata[DW-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == drnm_pkg::REG_LIMIT) ?
                  {{(drnm_pkg::CFG_DW - DW){1'b0}}, limit_r} : '0;

  assign out_valid        = out_valid_r;
  assign out_match_index  = out_match_index_r;
  assign out_found        = out_found_r;
  assign out_best_dist_sq = out_best_dist_sq_r;

  // Checks
  `DRNM_ASSERT_IMPL(a_count_bound, 1'b1, ref_count_r <= CW'(MAX_REFS))
  `DRNM_ASSERT_IMPL(a_read_in_list, rd_tag.valid, scan_k_r < ref_count_r)
  `DRNM_ASSERT_NEXT(a_found_below, finish && best_found, out_found && out_best_dist_sq < limit_r)
  `DRNM_ASSERT_IMPL(a_miss_code, out_valid && !out_found, out_match_index_r == drnm_pkg::NO_MATCH)

endmodule

FILE: tb/testbench.sv
module testbench;

  localparam int KIND_W = drnm_pkg::KIND_W;
  localparam int ETA_W  = drnm_pkg::ETA_W;
  localparam int PHI_W  = drnm_pkg::PHI_W;
  localparam int IDX_W  = drnm_pkg::IDX_W;
  localparam int DIST_W = drnm_pkg::DIST_W;
  localparam int CFG_AW = drnm_pkg::CFG_AW;
  localparam int CFG_DW = drnm_pkg::CFG_DW;

  localparam logic [KIND_W-1:0] KIND_START  = drnm_pkg::KIND_START;
  localparam logic [KIND_W-1:0] KIND_LOAD   = drnm_pkg::KIND_LOAD;
  localparam logic [KIND_W-1:0] KIND_QUERY  = drnm_pkg::KIND_QUERY;
  localparam logic              REG_LIMIT   = drnm_pkg::REG_LIMIT;
  localparam logic [PHI_W-1:0]  PHI_PI      = drnm_pkg::PHI_PI;
  localparam logic [PHI_W:0]    PHI_TWO_PI  = drnm_pkg::PHI_TWO_PI;
  localparam logic [DIST_W-1:0] DIST_MAX    = drnm_pkg::DIST_MAX;
  localparam logic [DIST_W-1:0] LIMIT_RESET = drnm_pkg::LIMIT_RESET;
  localparam logic [IDX_W-1:0]  NO_MATCH    = drnm_pkg::NO_MATCH;

  localparam int STORE_DEPTH   = 64;
  localparam int IDLE_LIMIT    = 5000;
  localparam int SETTLE_CYCLES = 80;
  localparam int PRINT_LIMIT   = 60;

  localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd3;
  localparam logic [CFG_AW-1:0] ADDR_LIMIT   = {REG_LIMIT, 2'b00};
  localparam logic [CFG_AW-1:0] ADDR_UNUSED  = {~REG_LIMIT, 2'b00};

  typedef struct packed {
    logic signed [IDX_W-1:0] match_index;
    logic                    found;
    logic [DIST_W-1:0]       best_dist_sq;
  } match_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [KIND_W-1:0]         in_kind = '0;
  logic signed [ETA_W-1:0]   in_eta = '0;
  logic signed [PHI_W-1:0]   in_phi = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [IDX_W-1:0]   out_match_index;
  logic                      out_found;
  logic [DIST_W-1:0]         out_best_dist_sq;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [CFG_AW-1:0]         paddr = '0;
  logic [CFG_DW-1:0]         pwdata = '0;
  logic [CFG_DW-1:0]         prdata;
  logic                      pready;

  // Predictor state: stored reference objects and the limit register
  logic signed [ETA_W-1:0]   stored_eta [STORE_DEPTH];
  logic signed [PHI_W-1:0]   stored_phi [STORE_DEPTH];
  int                        stored_count = 0;
  logic [DIST_W-1:0]         dist_limit = LIMIT_RESET;

  match_result_t             pending_matches [$];
  int                        error_count = 0;
  int                        idle_cycles = 0;
  int                        hold_off_left = 0;
  int                        stall_run = 0;
  bit                        no_idle = 1'b0;

  delta_r_nearest_match #(
    .MAX_REFS(STORE_DEPTH)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_eta          (in_eta),
    .in_phi          (in_phi),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_match_index (out_match_index),
    .out_found       (out_found),
    .out_best_dist_sq(out_best_dist_sq),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #5 clk = ~clk;

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_error(input string msg);
    if (error_count < PRINT_LIMIT)
      $display("testbench: error at %0t: %s", $time, msg);
    error_count++;
  endtask

  // Squared angular distance with phi folded about pi, saturated at 26 bits
  function automatic logic [DIST_W-1:0] angular_dist_sq(input int qeta, input int qphi,
                                                        input int reta, input int rphi);
    int     deta;
    int     dphi;
    longint sum;
    deta = qeta - reta;
    dphi = qphi - rphi;
    if (deta < 0) deta = -deta;
    if (dphi < 0) dphi = -dphi;
    if (dphi > int'(PHI_PI)) dphi = int'(PHI_TWO_PI) - dphi;
    sum = longint'(deta) * deta + longint'(dphi) * dphi;
    return (sum > longint'(DIST_MAX)) ? DIST_MAX : sum[DIST_W-1:0];
  endfunction

  // Scan the store in index order; only a strictly smaller distance replaces the best
  function automatic match_result_t nearest_match(input logic signed [ETA_W-1:0] eta,
                                                  input logic signed [PHI_W-1:0] phi);
    match_result_t     res;
    logic [DIST_W-1:0] best;
    logic [DIST_W-1:0] d;
    int                best_k;
    best = DIST_MAX;
    best_k = 0;
    for (int k = 0; k < stored_count; k++) begin
      d = angular_dist_sq(eta, phi, stored_eta[k], stored_phi[k]);
      if (k == 0 || d < best) begin
        best = d;
        best_k = k;
      end
    end
    res.found = (stored_count > 0) && (best < dist_limit);
    res.match_index = res.found ? best_k[IDX_W-1:0] : NO_MATCH;
    res.best_dist_sq = best;
    return res;
  endfunction

  // Apply one accepted item to the predictor
  task automatic predict_item(input logic [KIND_W-1:0] kind,
                              input logic signed [ETA_W-1:0] eta,
                              input logic signed [PHI_W-1:0] phi);
    case (kind)
      KIND_START: stored_count = 0;
      KIND_LOAD: begin
        if (stored_count < STORE_DEPTH) begin
          stored_eta[stored_count] = eta;
          stored_phi[stored_count] = phi;
          stored_count++;
        end
      end
      KIND_QUERY: pending_matches = {pending_matches, nearest_match(eta, phi)};
      default: ;
    endcase
  endtask

  // Offer one item after a random gap and hold it until accepted
  task automatic send_item(input logic [KIND_W-1:0] kind,
                           input logic signed [ETA_W-1:0] eta,
                           input logic signed [PHI_W-1:0] phi);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_eta <= eta;
    in_phi <= phi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(kind, eta, phi);
  endtask

  // Stop offering and wait until every expected result has come
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Write a register, then read back the limit register
  task automatic cfg_write(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    logic [CFG_DW-1:0] rdata;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ADDR_LIMIT) dist_limit = data[DIST_W-1:0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    psel <= 1'b1;
    paddr <= ADDR_LIMIT;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (rdata !== CFG_DW'(dist_limit))
      report_error($sformatf("limit readback got %h expected %h", rdata, dist_limit));
  endtask

  function automatic logic signed [ETA_W-1:0] random_eta();
    if ($urandom_range(0, 4) == 0) return ETA_W'($urandom);
    return ETA_W'(int'($urandom_range(0, 6520)) - 3260);
  endfunction

  // One event: start, a list of loads, then queries mostly close to a stored object
  task automatic run_event(input int n_loads, input int n_queries);
    logic signed [ETA_W-1:0] eta;
    logic signed [PHI_W-1:0] phi;
    int                      k;
    send_item(KIND_START, ETA_W'($urandom), PHI_W'($urandom));
    for (int i = 0; i < n_loads; i++) begin
      if (stored_count > 0 && stored_count < STORE_DEPTH && $urandom_range(0, 9) == 0) begin
        k = $urandom_range(0, stored_count - 1);
        send_item(KIND_LOAD, stored_eta[k], stored_phi[k]);
      end else begin
        send_item(KIND_LOAD, random_eta(), PHI_W'($urandom));
      end
    end
    for (int i = 0; i < n_queries; i++) begin
      if ($urandom_range(0, 19) == 0)
        send_item(KIND_IGNORED, ETA_W'($urandom), PHI_W'($urandom));
      if (stored_count > 0 && $urandom_range(0, 3) != 0) begin
        k = $urandom_range(0, stored_count - 1);
        eta = stored_eta[k] + ETA_W'(int'($urandom_range(0, 300)) - 150);
        phi = stored_phi[k] + PHI_W'(int'($urandom_range(0, 300)) - 150);
        send_item(KIND_QUERY, eta, phi);
      end else begin
        send_item(KIND_QUERY, random_eta(), PHI_W'($urandom));
      end
    end
  endtask

  function automatic int pick_load_count();
    if ($urandom_range(0, 6) == 0) return $urandom_range(40, 70);
    return $urandom_range(0, 12);
  endfunction

  // Extremes of the fields, ties, phi folding, saturation, ignored kind, empty store
  task automatic test_directed();
    send_item(KIND_QUERY, 13'sd0, 12'sd0);
    send_item(KIND_START, -13'sd4096, -12'sd2048);
    send_item(KIND_LOAD, 13'sd0, 12'sd0);
    send_item(KIND_LOAD, 13'sd0, 12'sd0);
    send_item(KIND_LOAD, 13'sd4095, 12'sd2047);
    send_item(KIND_LOAD, -13'sd4096, -12'sd2048);
    send_item(KIND_LOAD, 13'sd100, -12'sd2040);
    send_item(KIND_QUERY, 13'sd0, 12'sd0);
    send_item(KIND_QUERY, 13'sd50, 12'sd2040);
    send_item(KIND_QUERY, 13'sd4095, -12'sd2048);
    send_item(KIND_IGNORED, 13'sd4095, -12'sd1);
    send_item(KIND_QUERY, 13'sd3260, 12'sd0);
    send_item(KIND_START, 13'sd4095, 12'sd2047);
    send_item(KIND_LOAD, 13'sd4095, 12'sd0);
    send_item(KIND_QUERY, -13'sd4096, -12'sd2048);
    send_item(KIND_QUERY, -13'sd3260, 12'sd2047);
    send_item(KIND_START, 13'sd0, 12'sd0);
    send_item(KIND_QUERY, 13'sd1, 12'sd1);
    wait_drain();
  endtask

  // Limit extremes, the strict-below boundary, masking and an unmapped address
  task automatic test_limit_settings();
    cfg_write(ADDR_LIMIT, '0);
    run_event(6, 4);
    wait_drain();
    cfg_write(ADDR_LIMIT, '1);
    send_item(KIND_START, 13'sd0, 12'sd0);
    send_item(KIND_LOAD, 13'sd4095, 12'sd0);
    send_item(KIND_QUERY, -13'sd4096, 12'sd0);
    send_item(KIND_QUERY, 13'sd0, -12'sd2048);
    wait_drain();
    cfg_write(ADDR_LIMIT, 32'd10000);
    send_item(KIND_START, 13'sd0, 12'sd0);
    send_item(KIND_LOAD, 13'sd0, 12'sd0);
    send_item(KIND_QUERY, 13'sd100, 12'sd0);
    send_item(KIND_QUERY, 13'sd99, 12'sd0);
    send_item(KIND_QUERY, 13'sd0, -12'sd100);
    wait_drain();
    cfg_write(ADDR_UNUSED, 32'd123);
    run_event(4, 3);
    wait_drain();
    cfg_write(ADDR_LIMIT, 32'(DIST_MAX));
    run_event(5, 3);
    wait_drain();
  endtask

  // Hold off the result side so the block fills and stalls its input
  task automatic test_back_pressure();
    cfg_write(ADDR_LIMIT, 32'(LIMIT_RESET));
    run_event(8, 0);
    hold_off_left = 300;
    no_idle = 1'b1;
    for (int i = 0; i < 20; i++)
      send_item(KIND_QUERY, random_eta(), PHI_W'($urandom));
    no_idle = 1'b0;
    wait_drain();
  endtask

  // Random events with the limit changed between phases
  task automatic test_random_events();
    for (int phase = 0; phase < 4; phase++) begin
      cfg_write(ADDR_LIMIT, (phase == 3) ? 32'($urandom) : 32'($urandom_range(0, 400000)));
      for (int e = 0; e < 5; e++) begin
        no_idle = (phase == 1 && e < 2);
        run_event(pick_load_count(), $urandom_range(1, 6));
      end
      no_idle = 1'b0;
      wait_drain();
    end
  endtask

  // Result side: random stalls, long hold-off on request
  always @(posedge clk) begin
    if (hold_off_left > 0) begin
      out_stall <= 1'b1;
      hold_off_left = hold_off_left - 1;
    end else if (stall_run > 0) begin
      out_stall <= 1'b1;
      stall_run = stall_run - 1;
    end else if (!no_idle && rst_n && $urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      stall_run = pick_gap();
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Check each accepted result against the oldest expectation; watch for a hang
  always @(posedge clk) begin
    match_result_t want;
    bit            moved;
    if (rst_n) begin
      moved = (in_valid && !in_stall) || (psel && penable && pready);
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (pending_matches.size() == 0) begin
          report_error("result with no query waiting");
        end else begin
          want = pending_matches.pop_front();
          if (out_match_index !== want.match_index)
            report_error($sformatf("match_index got %h expected %h",
                                   out_match_index, want.match_index));
          if (out_found !== want.found)
            report_error($sformatf("found got %b expected %b", out_found, want.found));
          if (out_best_dist_sq !== want.best_dist_sq)
            report_error($sformatf("best_dist_sq got %0d expected %0d",
                                   out_best_dist_sq, want.best_dist_sq));
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_limit_settings();
    test_back_pressure();
    test_random_events();
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_matches.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
